@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the job priority queue: command and status
// codes, the job record, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_RETRIEVE   = 3'd1,
    CMD_CNT_CREATE = 3'd2,
    CMD_CNT_DONE   = 3'd3,
    CMD_READ_DONE  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [21:0] pid;
    logic [7:0]  number;
    logic [3:0]  prio;
    logic [3:0]  compute_time;
    logic [16:0] tag;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_CHECK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_MOVE
  } state_t;

  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_CREATE,
    CNT_DONE,
    CNT_READ
  } cnt_op_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_CARRY,
    WR_PARENT,
    WR_BEST
  } wr_sel_t;

  typedef struct packed {
    logic    res_load;
    status_t res_status;
    cnt_op_t cnt_op;
    logic    job_load;
    rd_sel_t rd_sel;
    logic    root_capture;
    logic    last_load;
    logic    left_eval;
    logic    right_eval;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    pos_to_parent;
    logic    pos_to_best;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic count_one;
    logic at_root;
    logic left_out;
    logic right_in;
    logic parent_greater;
    logic best_is_pos;
  } dp_stat_t;

endpackage

@@ rtl/max_heap_job_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// max_heap_job_priority_queue_top
// Bounded max-heap of job records keyed on priority, with created and
// completed event counters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// while a heap request sifts. Every request yields exactly one result, shown
// for a single cycle with out_valid high, in the cycle after the request ends;
// the receiver cannot stall it, so capture it then. Counter requests, refused
// inserts and empty retrieves finish in the accept cycle. An insert climbs
// one level per check and compare step and writes the record where it stops.
// A retrieve reads the root, then the last entry (and ends there when the heap
// held one entry), then descends one level per check, left, optional right
// and move step, writing the record where it stops. The heap sits in one RAM
// with one read and one write port and a registered read, so each step of a
// sift waits for the read.
// ----------------------------------------------------------------------------
module max_heap_job_priority_queue_top #(
  parameter int CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [21:0] in_producer_pid,
  input  logic [7:0]  in_producer_number,
  input  logic [3:0]  in_priority,
  input  logic [3:0]  in_compute_time,
  input  logic [16:0] in_job_tag,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [21:0] out_producer_pid,
  output logic [7:0]  out_producer_number,
  output logic [3:0]  out_priority,
  output logic [3:0]  out_compute_time,
  output logic [16:0] out_job_tag,
  output logic [31:0] out_counter_value
);
  import mhpq_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  mhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  mhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .stat                (stat),
    .in_producer_pid     (in_producer_pid),
    .in_producer_number  (in_producer_number),
    .in_priority         (in_priority),
    .in_compute_time     (in_compute_time),
    .in_job_tag          (in_job_tag),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_producer_pid    (out_producer_pid),
    .out_producer_number (out_producer_number),
    .out_priority        (out_priority),
    .out_compute_time    (out_compute_time),
    .out_job_tag         (out_job_tag),
    .out_counter_value   (out_counter_value)
  );

endmodule

@@ rtl/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 55,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for the queue: decodes a request, then walks the sift-up or
// sift-down loop one heap level at a time through the datapath.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0]            cmd,
  input  mhpq_pkg::dp_stat_t    stat,
  output mhpq_pkg::ctrl_cmd_t   ctl,
  output logic                  busy
);
  import mhpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_INSERT:   state_nxt = stat.full ? S_IDLE : S_UP_CHECK;
            CMD_RETRIEVE: state_nxt = stat.empty ? S_IDLE : S_DN_ROOT;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_UP_CHECK: state_nxt = stat.at_root ? S_IDLE : S_UP_CMP;
      S_UP_CMP:   state_nxt = stat.parent_greater ? S_IDLE : S_UP_CHECK;
      S_DN_ROOT:  state_nxt = S_DN_LAST;
      S_DN_LAST:  state_nxt = stat.count_one ? S_IDLE : S_DN_CHECK;
      S_DN_CHECK: state_nxt = stat.left_out ? S_IDLE : S_DN_LEFT;
      S_DN_LEFT:  state_nxt = stat.right_in ? S_DN_RIGHT : S_DN_MOVE;
      S_DN_RIGHT: state_nxt = S_DN_MOVE;
      S_DN_MOVE:  state_nxt = stat.best_is_pos ? S_IDLE : S_DN_CHECK;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl            = '0;
    ctl.res_status = STS_OK;
    ctl.cnt_op     = CNT_NONE;
    ctl.rd_sel     = RD_ROOT;
    ctl.wr_sel     = WR_CARRY;
    busy           = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.res_load = 1'b1;
          unique case (cmd)
            CMD_INSERT: begin
              if (stat.full) begin
                ctl.res_status = STS_FULL;
                ctl.finish     = 1'b1;
              end else begin
                ctl.job_load = 1'b1;
              end
            end
            CMD_RETRIEVE: begin
              if (stat.empty) begin
                ctl.res_status = STS_EMPTY;
                ctl.finish     = 1'b1;
              end else begin
                ctl.rd_sel = RD_ROOT;
              end
            end
            CMD_CNT_CREATE: begin
              ctl.cnt_op = CNT_CREATE;
              ctl.finish = 1'b1;
            end
            CMD_CNT_DONE: begin
              ctl.cnt_op = CNT_DONE;
              ctl.finish = 1'b1;
            end
            CMD_READ_DONE: begin
              ctl.cnt_op = CNT_READ;
              ctl.finish = 1'b1;
            end
            default: begin
              ctl.res_status = STS_BAD;
              ctl.finish     = 1'b1;
            end
          endcase
        end
      end
      S_UP_CHECK: begin
        if (stat.at_root) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = WR_CARRY;
          ctl.finish = 1'b1;
        end else begin
          ctl.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        ctl.wr_en = 1'b1;
        if (stat.parent_greater) begin
          ctl.wr_sel = WR_CARRY;
          ctl.finish = 1'b1;
        end else begin
          // pull the parent down and climb one level
          ctl.wr_sel        = WR_PARENT;
          ctl.pos_to_parent = 1'b1;
        end
      end
      S_DN_ROOT: begin
        ctl.root_capture = 1'b1;
        ctl.rd_sel       = RD_LAST;
      end
      S_DN_LAST: begin
        ctl.last_load = 1'b1;
        ctl.finish    = stat.count_one;
      end
      S_DN_CHECK: begin
        if (stat.left_out) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = WR_CARRY;
          ctl.finish = 1'b1;
        end else begin
          ctl.rd_sel = RD_LEFT;
        end
      end
      S_DN_LEFT: begin
        ctl.left_eval = 1'b1;
        ctl.rd_sel    = RD_RIGHT;
      end
      S_DN_RIGHT: begin
        ctl.right_eval = 1'b1;
      end
      S_DN_MOVE: begin
        ctl.wr_en = 1'b1;
        if (stat.best_is_pos) begin
          ctl.wr_sel = WR_CARRY;
          ctl.finish = 1'b1;
        end else begin
          // lift the larger child and descend
          ctl.wr_sel      = WR_BEST;
          ctl.pos_to_best = 1'b1;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

@@ rtl/mhpq_dpath.sv @@
// ----------------------------------------------------------------------------
// mhpq_dpath
// Heap storage, position and count registers, the record in flight, the
// event counters and the result registers.
// ----------------------------------------------------------------------------
module mhpq_dpath #(
  parameter int CAPACITY = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mhpq_pkg::ctrl_cmd_t        ctl,
  output mhpq_pkg::dp_stat_t         stat,
  input  logic [21:0]                in_producer_pid,
  input  logic [7:0]                 in_producer_number,
  input  logic [3:0]                 in_priority,
  input  logic [3:0]                 in_compute_time,
  input  logic [16:0]                in_job_tag,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [21:0]                out_producer_pid,
  output logic [7:0]                 out_producer_number,
  output logic [3:0]                 out_priority,
  output logic [3:0]                 out_compute_time,
  output logic [16:0]                out_job_tag,
  output logic [31:0]                out_counter_value
);
  import mhpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);

  logic [IDX_W-1:0] count_r, pos_r, best_idx_r;
  job_t             carry_r, best_rec_r, out_job_r;
  logic [CNT_W-1:0] created_r, completed_r, out_cnt_r;
  status_t          out_status_r;
  logic             out_valid_r;

  logic [IDX_W:0]   left_full, right_full;
  logic [IDX_W-1:0] left_idx, right_idx, parent_idx, rd_idx;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [$bits(job_t)-1:0] ram_rdata;
  job_t             rdata, wr_data;
  logic             left_take, right_take;

  assign left_full  = {pos_r, 1'b0};
  assign right_full = {pos_r, 1'b1};
  assign left_idx   = left_full[IDX_W-1:0];
  assign right_idx  = right_full[IDX_W-1:0];
  assign parent_idx = pos_r >> 1;
  assign rdata      = job_t'(ram_rdata);

  always_comb begin
    unique case (ctl.rd_sel)
      RD_ROOT:   rd_idx = IDX_W'(1);
      RD_LAST:   rd_idx = count_r;
      RD_PARENT: rd_idx = parent_idx;
      RD_LEFT:   rd_idx = left_idx;
      RD_RIGHT:  rd_idx = right_idx;
      default:   rd_idx = IDX_W'(1);
    endcase
  end

  always_comb begin
    unique case (ctl.wr_sel)
      WR_CARRY:  wr_data = carry_r;
      WR_PARENT: wr_data = rdata;
      WR_BEST:   wr_data = best_rec_r;
      default:   wr_data = carry_r;
    endcase
  end

  // slots are numbered from one
  assign rd_addr = AW'(rd_idx - IDX_W'(1));
  assign wr_addr = AW'(pos_r - IDX_W'(1));

  mhpq_ram #(
    .WIDTH ($bits(job_t)),
    .DEPTH (CAPACITY)
  ) u_heap (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign left_take  = rdata.prio > carry_r.prio;
  assign right_take = rdata.prio > best_rec_r.prio;

  always_comb begin
    stat                = '0;
    stat.full           = (count_r == IDX_W'(CAPACITY));
    stat.empty          = (count_r == '0);
    stat.count_one      = (count_r == IDX_W'(1));
    stat.at_root        = (pos_r == IDX_W'(1));
    stat.left_out       = (left_full > {1'b0, count_r});
    stat.right_in       = (right_full <= {1'b0, count_r});
    stat.parent_greater = rdata.prio > carry_r.prio;
    stat.best_is_pos    = (best_idx_r == pos_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      created_r   <= '0;
      completed_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (ctl.job_load) begin
        count_r <= count_r + IDX_W'(1);
      end else if (ctl.last_load) begin
        count_r <= count_r - IDX_W'(1);
      end
      if (ctl.res_load && ctl.cnt_op == CNT_CREATE) begin
        created_r <= created_r + CNT_W'(1);
      end
      if (ctl.res_load && ctl.cnt_op == CNT_DONE) begin
        completed_r <= completed_r + CNT_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.job_load) begin
      carry_r <= '{pid: in_producer_pid, number: in_producer_number,
                   prio: in_priority, compute_time: in_compute_time,
                   tag: in_job_tag};
      pos_r   <= count_r + IDX_W'(1);
    end else if (ctl.last_load) begin
      carry_r <= rdata;
      pos_r   <= IDX_W'(1);
    end else if (ctl.pos_to_parent) begin
      pos_r <= parent_idx;
    end else if (ctl.pos_to_best) begin
      pos_r <= best_idx_r;
    end

    if (ctl.left_eval) begin
      best_idx_r <= left_take ? left_idx : pos_r;
      best_rec_r <= left_take ? rdata : carry_r;
    end else if (ctl.right_eval && right_take) begin
      best_idx_r <= right_idx;
      best_rec_r <= rdata;
    end else if (ctl.last_load || ctl.pos_to_best) begin
      // nothing chosen yet at the new level
      best_idx_r <= '0;
    end

    if (ctl.res_load) begin
      out_status_r <= ctl.res_status;
      out_job_r    <= '0;
      unique case (ctl.cnt_op)
        CNT_CREATE: out_cnt_r <= created_r + CNT_W'(1);
        CNT_DONE:   out_cnt_r <= completed_r + CNT_W'(1);
        CNT_READ:   out_cnt_r <= completed_r;
        default:    out_cnt_r <= '0;
      endcase
    end else if (ctl.root_capture) begin
      out_job_r <= rdata;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_producer_pid    = out_job_r.pid;
  assign out_producer_number = out_job_r.number;
  assign out_priority        = out_job_r.prio;
  assign out_compute_time    = out_job_r.compute_time;
  assign out_job_tag         = out_job_r.tag;
  assign out_counter_value   = out_cnt_r;

endmodule

@@ tb/job_queue_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_queue_monitor
// Watches the request and result channels of the job priority queue. Keeps
// its own max-heap and counters and works out the result of every accepted
// request. Each result is checked field by field against the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module job_queue_monitor #(
  parameter int CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [21:0] in_producer_pid,
  input  logic [7:0]  in_producer_number,
  input  logic [3:0]  in_priority,
  input  logic [3:0]  in_compute_time,
  input  logic [16:0] in_job_tag,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [21:0] out_producer_pid,
  input  logic [7:0]  out_producer_number,
  input  logic [3:0]  out_priority,
  input  logic [3:0]  out_compute_time,
  input  logic [16:0] out_job_tag,
  input  logic [31:0] out_counter_value,
  output int          fail_count,
  output int          awaited_count,
  output int          full_seen,
  output int          empty_seen
);
  import mhpq_pkg::*;

  typedef struct packed {
    logic [21:0] pid;
    logic [7:0]  number;
    logic [3:0]  prio;
    logic [3:0]  compute_time;
    logic [16:0] tag;
  } job_rec_t;

  typedef struct packed {
    status_t          status;
    job_rec_t         job;
    logic [CNT_W-1:0] counter;
  } job_result_t;

  job_rec_t         heap [1:CAPACITY];
  int               heap_size;
  logic [CNT_W-1:0] created_total;
  logic [CNT_W-1:0] completed_total;
  job_result_t      awaited_results [$];

  function automatic void swap_slots(int a, int b);
    job_rec_t tmp;
    tmp     = heap[a];
    heap[a] = heap[b];
    heap[b] = tmp;
  endfunction

  function automatic job_result_t serve_request(logic [CMD_W-1:0] cmd, job_rec_t job);
    job_result_t res;
    int          pos;
    int          best;
    int          left;
    bit          done;
    res        = '0;
    res.status = STS_OK;
    case (cmd)
      CMD_INSERT: begin
        if (heap_size >= CAPACITY) begin
          res.status = STS_FULL;
        end else begin
          heap_size++;
          heap[heap_size] = job;
          pos  = heap_size;
          done = 0;
          // climb past parents of equal priority, stop under a strictly greater one
          while (pos > 1 && !done) begin
            if (heap[pos / 2].prio > heap[pos].prio) begin
              done = 1;
            end else begin
              swap_slots(pos / 2, pos);
              pos = pos / 2;
            end
          end
        end
      end
      CMD_RETRIEVE: begin
        if (heap_size == 0) begin
          res.status = STS_EMPTY;
        end else begin
          res.job = heap[1];
          heap[1] = heap[heap_size];
          heap_size--;
          pos  = 1;
          done = 0;
          while (!done) begin
            best = pos;
            left = 2 * pos;
            if (left <= heap_size && heap[left].prio > heap[best].prio) best = left;
            if (left + 1 <= heap_size && heap[left + 1].prio > heap[best].prio) best = left + 1;
            if (best == pos) begin
              done = 1;
            end else begin
              swap_slots(best, pos);
              pos = best;
            end
          end
        end
      end
      CMD_CNT_CREATE: begin
        created_total = created_total + CNT_W'(1);
        res.counter   = created_total;
      end
      CMD_CNT_DONE: begin
        completed_total = completed_total + CNT_W'(1);
        res.counter     = completed_total;
      end
      CMD_READ_DONE: begin
        res.counter = completed_total;
      end
      default: begin
        res.status = STS_BAD;
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    job_result_t want;
    job_rec_t    req;
    if (!rst_n) begin
      heap_size       = 0;
      created_total   = '0;
      completed_total = '0;
      fail_count      = 0;
      full_seen       = 0;
      empty_seen      = 0;
      awaited_results.delete();
      awaited_count <= 0;
    end else begin
      // check the result first: its request was accepted at an earlier edge
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with no request pending, status 0x%0h", $time, out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("producer_pid", 32'(want.job.pid), 32'(out_producer_pid));
          compare_field("producer_number", 32'(want.job.number), 32'(out_producer_number));
          compare_field("priority", 32'(want.job.prio), 32'(out_priority));
          compare_field("compute_time", 32'(want.job.compute_time), 32'(out_compute_time));
          compare_field("job_tag", 32'(want.job.tag), 32'(out_job_tag));
          compare_field("counter_value", want.counter, out_counter_value);
          if (want.status == STS_FULL) full_seen++;
          if (want.status == STS_EMPTY) empty_seen++;
        end
      end
      if (start && !busy) begin
        req.pid          = in_producer_pid;
        req.number       = in_producer_number;
        req.prio         = in_priority;
        req.compute_time = in_compute_time;
        req.tag          = in_job_tag;
        awaited_results.push_back(serve_request(in_cmd, req));
      end
      awaited_count <= awaited_results.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Request generator for the job priority queue. A directed pass hits the
// empty, full, tie, counter and illegal-command cases, then random phases
// lean toward filling, draining or mixing the heap, with random idle gaps in most phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mhpq_pkg::*;

  localparam int CAPACITY      = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [CMD_W-1:0] CMD_FIRST_BAD = CMD_READ_DONE + 1'b1;
  localparam logic [CMD_W-1:0] CMD_LAST      = '1;

  typedef struct packed {
    logic [21:0] pid;
    logic [7:0]  number;
    logic [3:0]  prio;
    logic [3:0]  compute_time;
    logic [16:0] tag;
  } job_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [21:0] in_producer_pid;
  logic [7:0]  in_producer_number;
  logic [3:0]  in_priority;
  logic [3:0]  in_compute_time;
  logic [16:0] in_job_tag;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [21:0] out_producer_pid;
  logic [7:0]  out_producer_number;
  logic [3:0]  out_priority;
  logic [3:0]  out_compute_time;
  logic [16:0] out_job_tag;
  logic [31:0] out_counter_value;

  int fail_count;
  int awaited_count;
  int full_seen;
  int empty_seen;
  int cycle_count = 0;
  int sent_count [8];
  bit gaps_on;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  max_heap_job_priority_queue_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_producer_pid    (in_producer_pid),
    .in_producer_number (in_producer_number),
    .in_priority        (in_priority),
    .in_compute_time    (in_compute_time),
    .in_job_tag         (in_job_tag),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_producer_pid   (out_producer_pid),
    .out_producer_number(out_producer_number),
    .out_priority       (out_priority),
    .out_compute_time   (out_compute_time),
    .out_job_tag        (out_job_tag),
    .out_counter_value  (out_counter_value)
  );

  job_queue_monitor #(
    .CAPACITY(CAPACITY)
  ) queue_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_producer_pid    (in_producer_pid),
    .in_producer_number (in_producer_number),
    .in_priority        (in_priority),
    .in_compute_time    (in_compute_time),
    .in_job_tag         (in_job_tag),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_producer_pid   (out_producer_pid),
    .out_producer_number(out_producer_number),
    .out_priority       (out_priority),
    .out_compute_time   (out_compute_time),
    .out_job_tag        (out_job_tag),
    .out_counter_value  (out_counter_value),
    .fail_count         (fail_count),
    .awaited_count      (awaited_count),
    .full_seen          (full_seen),
    .empty_seen         (empty_seen)
  );

  function automatic job_rec_t random_job(int prio_max);
    job_rec_t job;
    job.pid          = 22'($urandom);
    job.number       = 8'($urandom);
    job.prio         = 4'($urandom_range(0, prio_max));
    job.compute_time = 4'($urandom);
    job.tag          = 17'($urandom);
    return job;
  endfunction

  function automatic job_rec_t make_job(logic [21:0] pid, logic [7:0] number, logic [3:0] prio,
                                        logic [3:0] compute_time, logic [16:0] tag);
    job_rec_t job;
    job.pid          = pid;
    job.number       = number;
    job.prio         = prio;
    job.compute_time = compute_time;
    job.tag          = tag;
    return job;
  endfunction

  // Random idle after a request: mostly none, some short, a few long.
  task automatic idle_gap();
    int roll;
    int cycles;
    roll = $urandom_range(0, 99);
    if (gaps_on && roll >= 65) begin
      cycles = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      start  <= 1'b0;
      in_cmd <= CMD_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [CMD_W-1:0] cmd, job_rec_t job);
    in_cmd             <= cmd;
    in_producer_pid    <= job.pid;
    in_producer_number <= job.number;
    in_priority        <= job.prio;
    in_compute_time    <= job.compute_time;
    in_job_tag         <= job.tag;
    start              <= 1'b1;
    @(posedge clk);
    // hold the request until busy is low at an edge
    while (busy) @(posedge clk);
    sent_count[cmd]++;
    idle_gap();
  endtask

  // Hold off new requests until every pending result is back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
  endtask

  initial begin
    int roll;
    int ins_pct;
    int ret_pct;
    int prio_max;
    logic [CMD_W-1:0] cmd;
    start              <= 1'b0;
    rst_n              <= 1'b0;
    in_cmd             <= '0;
    in_producer_pid    <= '0;
    in_producer_number <= '0;
    in_priority        <= '0;
    in_compute_time    <= '0;
    in_job_tag         <= '0;
    foreach (sent_count[i]) sent_count[i] = 0;
    gaps_on = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty heap, extremes, ties, full heap, counters, illegal commands
    send_request(CMD_RETRIEVE, random_job(15));
    send_request(CMD_READ_DONE, random_job(15));
    send_request(CMD_INSERT, make_job('1, '1, '1, '1, '1));
    send_request(CMD_INSERT, make_job('0, '0, '0, '0, '0));
    for (int i = 1; i <= CAPACITY - 2; i++) begin
      send_request(CMD_INSERT, make_job(22'(i), 8'(i), 4'd7, 4'(i), 17'(i)));
    end
    send_request(CMD_INSERT, random_job(15));
    for (int i = 0; i <= CAPACITY; i++) begin
      send_request(CMD_RETRIEVE, random_job(15));
    end
    send_request(CMD_CNT_CREATE, random_job(15));
    send_request(CMD_CNT_DONE, random_job(15));
    send_request(CMD_CNT_DONE, random_job(15));
    send_request(CMD_READ_DONE, random_job(15));
    for (int c = CMD_FIRST_BAD; c <= CMD_LAST; c++) begin
      send_request(CMD_W'(c), random_job(15));
    end
    drain_results();

    // random phases: fill-heavy, drain-heavy, mixed
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 3)
        0:       begin ins_pct = 60; ret_pct = 25; end
        1:       begin ins_pct = 25; ret_pct = 60; end
        default: begin ins_pct = 43; ret_pct = 42; end
      endcase
      prio_max = ($urandom_range(0, 1) == 0) ? 3 : 15;
      gaps_on  = (phase % 4) != 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) cmd = CMD_INSERT;
        else if (roll < ins_pct + ret_pct) cmd = CMD_RETRIEVE;
        else if (roll < 93) cmd = CMD_W'($urandom_range(CMD_CNT_CREATE, CMD_READ_DONE));
        else cmd = CMD_W'($urandom_range(CMD_FIRST_BAD, CMD_LAST));
        send_request(cmd, random_job(prio_max));
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d inserts, %0d retrieves, %0d counter requests, %0d illegal commands",
             sent_count[CMD_INSERT], sent_count[CMD_RETRIEVE],
             sent_count[CMD_CNT_CREATE] + sent_count[CMD_CNT_DONE] + sent_count[CMD_READ_DONE],
             sent_count[5] + sent_count[6] + sent_count[7]);
    $display("inserts refused on a full heap: %0d, retrieves from an empty heap: %0d",
             full_seen, empty_seen);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
